[hdl/tsr_pkg.sv]
// Package for the TCP session responder: types, constants and flag codes.
`default_nettype none
package tsr_pkg;
   localparam int SESSIONS = 8;
   localparam int SLOT_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
   localparam int CNT_W = $clog2(SESSIONS + 1);

   localparam logic [7:0] FL_FIN = 8'h01;
   localparam logic [7:0] FL_SYN = 8'h02;
   localparam logic [7:0] FL_RST = 8'h04;
   localparam logic [7:0] FL_PSH = 8'h08;
   localparam logic [7:0] FL_ACK = 8'h10;

   localparam logic [2:0] CSR_LOCAL_IP    = 3'd0;
   localparam logic [2:0] CSR_CLIENT_OPEN = 3'd1;
   localparam logic [2:0] CSR_CLIENT_TCP  = 3'd2;
   localparam logic [2:0] CSR_CLIENT_LPORT = 3'd3;
   localparam logic [2:0] CSR_CLIENT_RPORT = 3'd4;
   localparam logic [2:0] CSR_CLIENT_RIP  = 3'd5;
   localparam logic [2:0] CSR_CLIENT_TICK = 3'd6;
   localparam logic [2:0] CSR_TIMEOUT     = 3'd7;

   typedef struct packed {
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [7:0]  seg_flags;
      logic [31:0] seg_seq;
      logic [31:0] seg_ack;
      logic [15:0] payload_len;
      logic [31:0] now;
      logic [31:0] fresh_seq;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  reply_flags;
      logic [31:0] reply_seq;
      logic [31:0] reply_ack;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] tick;
      logic [31:0] seq;
      logic [7:0]  sent;
      logic [31:0] peer_ip;
      logic [31:0] own_ip;
      logic [15:0] peer_port;
      logic [15:0] own_port;
   } slot_type;

   // Reply formation result
   typedef struct packed {
      logic        ok;
      logic [7:0]  flags;
      logic [31:0] seq;
      logic [31:0] ack;
      logic [7:0]  sent_after;
      logic [31:0] seq_after;
   } reply_type;
endpackage
`default_nettype wire

[hdl/tsr_reply.sv]
// Reply formation: flag rules and acknowledgement for one reply.
`default_nettype none
module tsr_reply (
   input  wire logic [7:0]  seg_flags,
   input  wire logic [7:0]  sent,
   input  wire logic [31:0] seq,
   input  wire logic [31:0] seg_seq,
   input  wire logic [31:0] seg_ack,
   input  wire logic [15:0] payload_len,
   output tsr_pkg::reply_type reply
);
   logic [7:0]  f;
   logic [31:0] addend;
   logic        ok;
   logic        finack;
   logic [7:0]  fin_reply;
   logic [7:0]  sent_now;

   always_comb begin
      fin_reply = (sent == (tsr_pkg::FL_ACK | tsr_pkg::FL_FIN)) ?
                  (tsr_pkg::FL_ACK | tsr_pkg::FL_FIN) : tsr_pkg::FL_ACK;
      f = 8'd0;
      addend = 32'd1;
      ok = 1'b1;
      finack = 1'b0;
      case (seg_flags)
         tsr_pkg::FL_SYN: f = tsr_pkg::FL_ACK | tsr_pkg::FL_SYN;
         tsr_pkg::FL_ACK | tsr_pkg::FL_PSH: begin
            f = tsr_pkg::FL_ACK | tsr_pkg::FL_PSH;
            addend = {16'd0, payload_len};
         end
         tsr_pkg::FL_ACK | tsr_pkg::FL_FIN: f = tsr_pkg::FL_ACK | tsr_pkg::FL_FIN;
         tsr_pkg::FL_ACK | tsr_pkg::FL_FIN | tsr_pkg::FL_PSH,
         tsr_pkg::FL_FIN | tsr_pkg::FL_PSH: begin
            f = fin_reply;
            finack = 1'b1;
            addend = (payload_len == 16'd0) ? 32'd1 : {16'd0, payload_len};
         end
         tsr_pkg::FL_FIN: begin
            f = fin_reply;
            finack = 1'b1;
         end
         default: ok = 1'b0;
      endcase
      // held state keeps its flags and forms a reply for any flags
      if (sent == (tsr_pkg::FL_RST | tsr_pkg::FL_FIN)) begin
         ok = 1'b1;
         finack = 1'b0;
         sent_now = sent;
         addend = 32'd0;
      end else begin
         sent_now = f;
      end
      reply.ok = ok;
      reply.flags = sent_now;
      reply.seq = (seg_flags != tsr_pkg::FL_SYN) ? seg_ack : seq;
      reply.ack = seg_seq + addend;
      reply.seq_after = reply.seq;
      reply.sent_after = finack ? (tsr_pkg::FL_ACK | tsr_pkg::FL_FIN) : sent_now;
   end
endmodule
`default_nettype wire

[hdl/tcp_session_responder.sv]
// TCP session responder: one slot compared per cycle, then reply formation.
// Flow: the table is scanned one slot per cycle through a single compare unit, then
// the hit slot is updated (S_ACT) and one or two results are sent (S_OUT1, S_OUT2).
// Requests: one segment at a time; a new request is taken once results are gone.
// Reset: synchronous; registers return to reset values and the session table is
// cleared at once (flip-flop slots).
`default_nettype none
module tcp_session_responder (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire tsr_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output tsr_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [2:0]       csr_index,
   input  wire logic [31:0]      csr_data
);
   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_ACT, S_OUT1, S_OUT2} state_type;

   state_type state_ff;
   tsr_pkg::req_type req_ff;
   tsr_pkg::slot_type slot_ff [tsr_pkg::SESSIONS];
   logic [tsr_pkg::CNT_W-1:0] idx_ff;
   logic [tsr_pkg::SLOT_W-1:0] hit_ff;
   logic found_ff;
   tsr_pkg::rsp_type rsp_ff;
   logic rsp_valid_ff;
   tsr_pkg::rsp_type second_ff;
   logic [31:0] local_ip_ff, client_rip_ff, client_tick_ff;
   logic client_open_ff, client_tcp_ff;
   logic [15:0] client_lport_ff, client_rport_ff, timeout_ff;

   // shared compare unit over the slot at idx
   tsr_pkg::slot_type cur;
   logic [tsr_pkg::SLOT_W-1:0] idx_s;
   logic same, live, take;
   logic [31:0] age;
   assign idx_s = idx_ff[tsr_pkg::SLOT_W-1:0];
   assign cur = slot_ff[idx_s];
   assign age = req_ff.now - cur.tick;
   assign live = age <= {16'd0, timeout_ff};
   assign same = cur.peer_ip == req_ff.src_ip && cur.own_ip == req_ff.dst_ip &&
                 cur.peer_port == req_ff.src_port && cur.own_port == req_ff.dst_port;
   assign take = (req_ff.seg_flags == tsr_pkg::FL_SYN) ?
                 (cur.tick == 32'd0 || !live || same) : (live && same);

   // reply unit, fed from the hit slot or, on the client path, from fixed flags and the fresh sequence
   tsr_pkg::slot_type hs;
   logic client_hit, client_live;
   logic [7:0] r_sent;
   logic [31:0] r_seq;
   tsr_pkg::reply_type rep;
   assign hs = slot_ff[hit_ff];
   assign client_hit = client_open_ff && client_tcp_ff &&
                       req_data.dst_port == client_lport_ff &&
                       req_data.src_port == client_rport_ff &&
                       req_data.src_ip == client_rip_ff;
   assign client_live = (req_ff.now - client_tick_ff) <= {16'd0, timeout_ff};
   always_comb begin
      if (found_ff) begin
         r_sent = hs.sent;
         r_seq = hs.seq;
      end else begin
         r_sent = tsr_pkg::FL_RST | tsr_pkg::FL_FIN | tsr_pkg::FL_ACK;
         r_seq = req_ff.fresh_seq;
      end
   end
   tsr_reply u_reply (
      .seg_flags(req_ff.seg_flags), .sent(r_sent), .seq(r_seq),
      .seg_seq(req_ff.seg_seq), .seg_ack(req_ff.seg_ack),
      .payload_len(req_ff.payload_len), .reply(rep)
   );

   // second reply is formed from the updated slot
   tsr_pkg::reply_type rep2;
   tsr_reply u_reply2 (
      .seg_flags(req_ff.seg_flags), .sent(rep.sent_after), .seq(rep.seq_after),
      .seg_seq(req_ff.seg_seq), .seg_ack(req_ff.seg_ack),
      .payload_len(req_ff.payload_len), .reply(rep2)
   );

   logic rsp_take;
   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign req_stall = state_ff != S_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // state, table and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         found_ff <= 1'b0;
         idx_ff <= '0;
         hit_ff <= '0;
         local_ip_ff <= 32'd0;
         client_open_ff <= 1'b0;
         client_tcp_ff <= 1'b1;
         client_lport_ff <= 16'd0;
         client_rport_ff <= 16'd0;
         client_rip_ff <= 32'd0;
         client_tick_ff <= 32'd0;
         timeout_ff <= 16'd5;
         for (int i = 0; i < tsr_pkg::SESSIONS; i++) slot_ff[i] <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               tsr_pkg::CSR_LOCAL_IP:     local_ip_ff <= csr_data;
               tsr_pkg::CSR_CLIENT_OPEN:  client_open_ff <= csr_data[0];
               tsr_pkg::CSR_CLIENT_TCP:   client_tcp_ff <= csr_data[0];
               tsr_pkg::CSR_CLIENT_LPORT: client_lport_ff <= csr_data[15:0];
               tsr_pkg::CSR_CLIENT_RPORT: client_rport_ff <= csr_data[15:0];
               tsr_pkg::CSR_CLIENT_RIP:   client_rip_ff <= csr_data;
               tsr_pkg::CSR_CLIENT_TICK:  client_tick_ff <= csr_data;
               tsr_pkg::CSR_TIMEOUT:      timeout_ff <= csr_data[15:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff <= req_data;
                  idx_ff <= '0;
                  found_ff <= 1'b0;
                  if (req_data.dst_ip != local_ip_ff) state_ff <= S_IDLE;
                  else if (client_hit) state_ff <= S_ACT;
                  else state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (take) begin
                  found_ff <= 1'b1;
                  hit_ff <= idx_s;
                  if (req_ff.seg_flags == tsr_pkg::FL_SYN) begin
                     slot_ff[idx_s].tick <= req_ff.now;
                     slot_ff[idx_s].seq <= req_ff.fresh_seq;
                     slot_ff[idx_s].peer_ip <= req_ff.src_ip;
                     slot_ff[idx_s].own_ip <= req_ff.dst_ip;
                     slot_ff[idx_s].peer_port <= req_ff.src_port;
                     slot_ff[idx_s].own_port <= req_ff.dst_port;
                  end
                  state_ff <= S_ACT;
               end else if (idx_ff == tsr_pkg::CNT_W'(tsr_pkg::SESSIONS - 1)) begin
                  state_ff <= S_IDLE;
               end
               idx_ff <= idx_ff + 1'b1;
            end
            S_ACT: begin
               if (!found_ff) begin
                  // client socket path
                  rsp_ff.kind <= client_live;
                  rsp_ff.reply_flags <= client_live ? 8'd0 : rep.flags;
                  rsp_ff.reply_seq <= client_live ? 32'd0 : rep.seq;
                  rsp_ff.reply_ack <= client_live ? 32'd0 : rep.ack;
                  rsp_ff.last <= 1'b1;
                  if (client_live || rep.ok) begin
                     rsp_valid_ff <= 1'b1;
                     state_ff <= S_OUT2;
                  end else state_ff <= S_IDLE;
               end else if (req_ff.seg_flags == tsr_pkg::FL_ACK &&
                            hs.sent == tsr_pkg::FL_FIN) begin
                  slot_ff[hit_ff] <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  slot_ff[hit_ff].tick <= req_ff.now;
                  if (rep.ok) begin
                     logic two;
                     two = (req_ff.seg_flags & tsr_pkg::FL_FIN) != 8'd0 &&
                           rep.sent_after == (tsr_pkg::FL_ACK | tsr_pkg::FL_FIN);
                     rsp_ff <= '{kind: 1'b0, reply_flags: rep.flags,
                                 reply_seq: rep.seq, reply_ack: rep.ack, last: !two};
                     rsp_valid_ff <= 1'b1;
                     second_ff <= '{kind: 1'b0, reply_flags: rep2.flags,
                                    reply_seq: rep2.seq, reply_ack: rep2.ack,
                                    last: 1'b1};
                     if (two) begin
                        slot_ff[hit_ff].sent <= rep2.sent_after;
                        slot_ff[hit_ff].seq <= rep2.seq_after;
                        state_ff <= S_OUT1;
                     end else begin
                        slot_ff[hit_ff].sent <= rep.sent_after;
                        slot_ff[hit_ff].seq <= rep.seq_after;
                        state_ff <= S_OUT2;
                     end
                  end else state_ff <= S_IDLE;
               end
            end
            S_OUT1: begin
               // first reply leaves, second one takes its place
               if (rsp_take) begin
                  rsp_ff <= second_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_OUT2;
               end
            end
            S_OUT2: begin
               if (rsp_take) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // results appear only after a request has been taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == S_OUT1 || state_ff == S_OUT2))
      else $error("result without a request in flight");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT1 && rsp_valid) |-> !rsp_data.last)
      else $error("first of two replies marked last");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> idx_ff < tsr_pkg::CNT_W'(tsr_pkg::SESSIONS))
      else $error("scan index past table");
endmodule
`default_nettype wire
